// File: rtl/gfco_pkg.sv
// Shared constants, types and helpers of the gaze-follow crop offset block.
`default_nettype none
package gfco_pkg;
   localparam int FRAC_BITS = 8;
   localparam int ROW_BITS  = 12;
   localparam int OFS_W     = ROW_BITS + FRAC_BITS + 1;
   localparam int GAZE_W    = ROW_BITS + FRAC_BITS;
   localparam int DT_W      = 7 + FRAC_BITS;
   localparam int TOP_W     = ROW_BITS;
   localparam int BH_W      = ROW_BITS + 1;
   localparam int TIMER_W   = 24;
   localparam int MODE_W    = 2;
   localparam int FRAC16_W  = 16;
   localparam int MS_W      = 16;
   localparam int KEEP_W    = 12;
   localparam int IMG_W     = 13;
   // signed working width for offsets and limits
   localparam int WW        = 27;
   // shared divider: numerator and divisor widths
   localparam int DIV_NW    = DT_W + 16;
   localparam int DIV_DW    = MS_W + FRAC_BITS;
   localparam int CSR_AW    = 5;
   localparam int REQ_DW    = 64;
   localparam int RSP_DW    = 40;
   localparam int TAYLOR_N  = 12;
   localparam logic [31:0] EXP_M1_Q30 = 32'd395007542;
   localparam logic [31:0] ONE_Q30    = 32'd1 << 30;

   // register indexes
   localparam logic [2:0] REG_FOLLOW_MODE = 3'd0;
   localparam logic [2:0] REG_DEADZONE    = 3'd1;
   localparam logic [2:0] REG_REACH       = 3'd2;
   localparam logic [2:0] REG_HOLD        = 3'd3;
   localparam logic [2:0] REG_GLIDE       = 3'd4;
   localparam logic [2:0] REG_EDGE_KEEP   = 3'd5;
   localparam logic [2:0] REG_IMG_HEIGHT  = 3'd6;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // clamp v into [lo, hi], low bound tested first
   function automatic logic signed [WW-1:0] clamp_w(input logic signed [WW-1:0] v,
                                                    input logic signed [WW-1:0] lo,
                                                    input logic signed [WW-1:0] hi);
      logic signed [WW-1:0] r;
      r = v;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      return r;
   endfunction

   // saturate to the signed offset width
   function automatic logic signed [OFS_W-1:0] sat_ofs(input logic signed [WW-1:0] v);
      logic signed [WW-1:0] lim;
      logic signed [OFS_W-1:0] r;
      lim = WW'(1) <<< (OFS_W - 1);
      if (v < -lim) r = OFS_W'(-lim);
      else if (v > lim - 1) r = OFS_W'(lim - 1);
      else r = OFS_W'(v);
      return r;
   endfunction
endpackage
`default_nettype wire

// File: rtl/gfco_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module gfco_div
   import gfco_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_NW-1:0] num,
   input  wire logic [DIV_DW-1:0] den,
   output div_sts_type            sts,
   output logic [DIV_NW-1:0]      quo
);
   localparam int CNT_W = $clog2(DIV_NW + 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DIV_DW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW:0]   rem_sh;
   logic              ge;

   // one shift-subtract step
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_NW-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
         cnt_in  = CNT_W'(DIV_NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_DW'(rem_sh - {1'b0, den_ff}) : DIV_DW'(rem_sh);
         quo_in = {quo_ff[DIV_NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo      = quo_ff;
endmodule
`default_nettype wire

// File: rtl/gaze_follow_crop_offset.sv
// Gaze-following vertical crop offset: top level with sequencer and registers.
//
// One request per video frame. A request takes a sequence of steps through a
// single shared 32x32 multiplier and a bit-serial divider: three multiplies
// for the deadzone edges and reach, a push and a clamp step, the dt/glide
// division, twelve Taylor terms of two steps each (the product, then the divide
// by the term index through a reciprocal, or a shift for indexes 1 and 2), up to
// 31 multiplies by exp(-1), then the gain, glide and row steps. When glide is
// zero the division, Taylor, exp(-1) and gain steps are skipped; when the ratio
// reaches 32 the Taylor, exp(-1) and gain steps are skipped; when follow is off
// the block goes straight to the row step. The result stays until taken, and
// only then does the block return to idle and take the next request.
`default_nettype none
module gaze_follow_crop_offset
   import gfco_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // gaze_row[19:0], frame_time[34:20], box_top[46:35], box_height[59:47]
   input  wire logic [REQ_DW-1:0] req_tdata,
   // gaze_valid[0]
   input  wire logic              req_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // glided_offset[20:0], crop_row[32:21]
   output logic [RSP_DW-1:0]      rsp_tdata,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_ZT    = 14'b00000000000010,
      ST_ZB    = 14'b00000000000100,
      ST_REACH = 14'b00000000001000,
      ST_PUSH  = 14'b00000000010000,
      ST_CLAMP = 14'b00000000100000,
      ST_XDIV  = 14'b00000001000000,
      ST_TMUL  = 14'b00000010000000,
      ST_TDIV  = 14'b00000100000000,
      ST_EMUL  = 14'b00001000000000,
      ST_GAIN  = 14'b00010000000000,
      ST_GLIDE = 14'b00100000000000,
      ST_ROW   = 14'b01000000000000,
      ST_OUT   = 14'b10000000000000
   } state_type;

   localparam logic [16:0] K_ONE = 17'd65536;

   // ceil(2^33 / i): floor(a*r >> 33) is exact for a below 2^30; i = 1, 2 are shifts
   function automatic logic [31:0] recip_q33(input logic [3:0] i);
      logic [31:0] r;
      case (i)
         4'd3:    r = 32'd2863311531;
         4'd4:    r = 32'd2147483648;
         4'd5:    r = 32'd1717986919;
         4'd6:    r = 32'd1431655766;
         4'd7:    r = 32'd1227133514;
         4'd8:    r = 32'd1073741824;
         4'd9:    r = 32'd954437177;
         4'd10:   r = 32'd858993460;
         4'd11:   r = 32'd780903145;
         4'd12:   r = 32'd715827883;
         default: r = '0;
      endcase
      return r;
   endfunction

   state_type state_ff, state_in;

   // configuration registers
   logic [MODE_W-1:0]   mode_ff;
   logic [FRAC16_W-1:0] dz_ff, rfr_ff;
   logic [MS_W-1:0]     hold_ff, glide_ff;
   logic [KEEP_W-1:0]   keep_ff;
   logic [IMG_W-1:0]    img_ff;
   logic                csr_wr;

   // latched request
   logic              gv_ff, gv_in;
   logic [GAZE_W-1:0] gaze_ff, gaze_in;
   logic [DT_W-1:0]   dt_ff, dt_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic [BH_W-1:0]   bh_ff, bh_in;

   // state kept across frames
   logic signed [OFS_W-1:0] tgt_ff, tgt_in, cur_ff, cur_in;
   logic [TIMER_W-1:0]      rest_ff, rest_in;

   // per-frame working registers
   logic [21:0]          zt_ff, zt_in, zb_ff, zb_in, reach_ff, reach_in;
   logic signed [WW-1:0] wt_ff, wt_in;
   logic [4:0]           n_ff, n_in;
   logic [15:0]          f_ff, f_in;
   logic [DIV_NW-1:0]    t_ff, t_in;
   logic [31:0]          sum_ff, sum_in;
   logic [3:0]           i_ff, i_in;
   logic [16:0]          k_ff, k_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0]    rsp_data_ff, rsp_data_in;

   // shared multiplier and divider
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       mul_p;
   logic              div_start;
   logic [DIV_NW-1:0] div_num, div_quo;
   logic [DIV_DW-1:0] div_den;
   div_sts_type       div_sts;

   // combinational helpers
   logic                 follows;
   logic signed [WW-1:0] home_s, gaze_s, amin, amax, pushed, lo_h, hi_l, reach_s;
   logic signed [WW-1:0] diff, mag, step, tsum, rowv, limit_s;
   logic [TIMER_W:0]     rest_sum;
   logic [TIMER_W-1:0]   rest_sat;
   logic [DIV_NW-1:0]    tq;
   logic [31:0]          sum_upd;
   logic [17:0]          e16;
   logic [47:0]          m2;

   gfco_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .sts   (div_sts),
      .quo   (div_quo)
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         dz_ff    <= 16'd32768;
         rfr_ff   <= 16'd16384;
         hold_ff  <= 16'd2000;
         glide_ff <= 16'd300;
         keep_ff  <= '0;
         img_ff   <= 13'd1080;
      end else if (csr_wr) begin
         case (csr_paddr[CSR_AW-1:2])
            REG_FOLLOW_MODE: mode_ff  <= csr_pwdata[MODE_W-1:0];
            REG_DEADZONE:    dz_ff    <= csr_pwdata[FRAC16_W-1:0];
            REG_REACH:       rfr_ff   <= csr_pwdata[FRAC16_W-1:0];
            REG_HOLD:        hold_ff  <= csr_pwdata[MS_W-1:0];
            REG_GLIDE:       glide_ff <= csr_pwdata[MS_W-1:0];
            REG_EDGE_KEEP:   keep_ff  <= csr_pwdata[KEEP_W-1:0];
            REG_IMG_HEIGHT:  img_ff   <= csr_pwdata[IMG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_AW-1:2])
         REG_FOLLOW_MODE: csr_prdata = 32'(mode_ff);
         REG_DEADZONE:    csr_prdata = 32'(dz_ff);
         REG_REACH:       csr_prdata = 32'(rfr_ff);
         REG_HOLD:        csr_prdata = 32'(hold_ff);
         REG_GLIDE:       csr_prdata = 32'(glide_ff);
         REG_EDGE_KEEP:   csr_prdata = 32'(keep_ff);
         REG_IMG_HEIGHT:  csr_prdata = 32'(img_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_ZT:    begin mul_a = 32'(K_ONE - 17'(dz_ff)); mul_b = 32'(bh_ff); end
         ST_ZB:    begin mul_a = 32'(K_ONE + 17'(dz_ff)); mul_b = 32'(bh_ff); end
         ST_REACH: begin mul_a = 32'(rfr_ff); mul_b = 32'(bh_ff); end
         ST_TMUL:  begin mul_a = 32'(t_ff); mul_b = 32'(f_ff); end
         ST_TDIV:  begin mul_a = 32'(t_ff); mul_b = recip_q33(i_ff); end
         ST_EMUL:  begin mul_a = sum_ff; mul_b = EXP_M1_Q30; end
         ST_GLIDE: begin mul_a = 32'(mag); mul_b = 32'(k_ff); end
         default: ;
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   // arithmetic shared by the steps
   always_comb begin
      follows  = mode_ff[0] && (bh_ff != '0) && (14'(bh_ff) < 14'(img_ff));
      home_s   = $signed(WW'(top_ff) << FRAC_BITS);
      gaze_s   = $signed(WW'(gaze_ff));
      amin     = gaze_s - home_s - $signed(WW'(zb_ff));
      amax     = gaze_s - home_s - $signed(WW'(zt_ff));
      pushed   = clamp_w(wt_ff, amin, amax);
      rest_sum = (TIMER_W+1)'(rest_ff) + (TIMER_W+1)'(dt_ff);
      rest_sat = rest_sum[TIMER_W] ? {TIMER_W{1'b1}} : rest_sum[TIMER_W-1:0];
      reach_s  = $signed(WW'(reach_ff));
      // edge limits: highest <= 0 <= lowest
      lo_h     = $signed(WW'(keep_ff) << FRAC_BITS) - home_s;
      if (lo_h > 0) lo_h = '0;
      hi_l     = ($signed(WW'(img_ff)) - $signed(WW'(bh_ff))) * $signed(WW'(1 << FRAC_BITS))
                 - home_s - $signed(WW'(keep_ff) << FRAC_BITS);
      if (hi_l < 0) hi_l = '0;
      diff     = $signed(WW'(tgt_ff)) - $signed(WW'(cur_ff));
      mag      = (diff < 0) ? -diff : diff;
      m2       = 48'((mul_p + 64'd32768) >> 16);
      step     = (diff < 0) ? -$signed(WW'(m2)) : $signed(WW'(m2));
      // Taylor term divided by its index
      if (i_ff == 4'd1)      tq = t_ff;
      else if (i_ff == 4'd2) tq = t_ff >> 1;
      else                   tq = DIV_NW'(mul_p >> 33);
      sum_upd  = i_ff[0] ? ((32'(tq) > sum_ff) ? 32'd0 : sum_ff - 32'(tq))
                         : sum_ff + 32'(tq);
      e16      = 18'((33'(sum_ff) + 33'd8192) >> 14);
      tsum     = home_s + $signed(WW'(cur_ff)) + $signed(WW'(1 << (FRAC_BITS - 1)));
      rowv     = (tsum < 0) ? '0 : (tsum >>> FRAC_BITS);
      limit_s  = (14'(img_ff) > 14'(bh_ff)) ?
                 $signed(WW'(img_ff)) - $signed(WW'(bh_ff)) : '0;
      if (limit_s > $signed(WW'((1 << ROW_BITS) - 1))) limit_s = WW'((1 << ROW_BITS) - 1);
      if (rowv > limit_s) rowv = limit_s;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      gv_in        = gv_ff;
      gaze_in      = gaze_ff;
      dt_in        = dt_ff;
      top_in       = top_ff;
      bh_in        = bh_ff;
      tgt_in       = tgt_ff;
      cur_in       = cur_ff;
      rest_in      = rest_ff;
      zt_in        = zt_ff;
      zb_in        = zb_ff;
      reach_in     = reach_ff;
      wt_in        = wt_ff;
      n_in         = n_ff;
      f_in         = f_ff;
      t_in         = t_ff;
      sum_in       = sum_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               gv_in    = req_tuser;
               gaze_in  = req_tdata[GAZE_W-1:0];
               dt_in    = req_tdata[GAZE_W +: DT_W];
               top_in   = req_tdata[GAZE_W+DT_W +: TOP_W];
               bh_in    = req_tdata[GAZE_W+DT_W+TOP_W +: BH_W];
               state_in = ST_ZT;
            end
         end
         ST_ZT: begin
            if (!follows) begin
               tgt_in   = '0;
               cur_in   = '0;
               rest_in  = '0;
               state_in = ST_ROW;
            end else begin
               zt_in    = 22'(((mul_p << FRAC_BITS) + 64'd65536) >> 17);
               wt_in    = $signed(WW'(tgt_ff));
               state_in = ST_ZB;
            end
         end
         ST_ZB: begin
            zb_in    = 22'(((mul_p << FRAC_BITS) + 64'd65536) >> 17);
            state_in = ST_REACH;
         end
         ST_REACH: begin
            reach_in = 22'(((mul_p << FRAC_BITS) + 64'd32768) >> 16);
            state_in = ST_PUSH;
         end
         // gaze push, rest timer and return home
         ST_PUSH: begin
            if (gv_ff) begin
               if (pushed != wt_ff) begin
                  wt_in   = pushed;
                  rest_in = '0;
               end else begin
                  rest_in = rest_sat;
                  if (mode_ff[1] && (rest_sat >= (TIMER_W'(hold_ff) << FRAC_BITS)))
                     wt_in = clamp_w('0, amin, amax);
               end
            end
            state_in = ST_CLAMP;
         end
         // reach and edge limits, then kick off the gain
         ST_CLAMP: begin
            tgt_in = sat_ofs(clamp_w(clamp_w(wt_ff, -reach_s, reach_s), lo_h, hi_l));
            if (glide_ff == '0) begin
               k_in     = K_ONE;
               state_in = ST_GLIDE;
            end else begin
               div_start = 1'b1;
               div_num   = {dt_ff, 16'd0};
               div_den   = {glide_ff, {FRAC_BITS{1'b0}}};
               state_in  = ST_XDIV;
            end
         end
         ST_XDIV: begin
            if (div_sts.done) begin
               if (div_quo[DIV_NW-1:21] != '0) begin
                  k_in     = K_ONE;
                  state_in = ST_GLIDE;
               end else begin
                  n_in     = div_quo[20:16];
                  f_in     = div_quo[15:0];
                  t_in     = DIV_NW'(ONE_Q30);
                  sum_in   = ONE_Q30;
                  i_in     = 4'd1;
                  state_in = ST_TMUL;
               end
            end
         end
         // Taylor term: t = ((t*f) >> 16) / i
         ST_TMUL: begin
            t_in     = DIV_NW'(mul_p >> 16);
            state_in = ST_TDIV;
         end
         ST_TDIV: begin
            t_in = tq;
            if (i_ff == 4'(TAYLOR_N)) begin
               sum_in   = (sum_upd > ONE_Q30) ? ONE_Q30 : sum_upd;
               state_in = ST_EMUL;
            end else begin
               sum_in   = sum_upd;
               i_in     = i_ff + 1'b1;
               state_in = ST_TMUL;
            end
         end
         // one exp(-1) factor per whole unit
         ST_EMUL: begin
            if (n_ff == '0) begin
               state_in = ST_GAIN;
            end else begin
               sum_in = 32'((mul_p + 64'd536870912) >> 30);
               n_in   = n_ff - 1'b1;
            end
         end
         ST_GAIN: begin
            k_in     = (e16 > 18'(K_ONE)) ? 17'd0 : 17'(18'(K_ONE) - e16);
            state_in = ST_GLIDE;
         end
         ST_GLIDE: begin
            cur_in   = sat_ofs($signed(WW'(cur_ff)) + step);
            state_in = ST_ROW;
         end
         ST_ROW: begin
            rsp_data_in  = RSP_DW'({ROW_BITS'(rowv), cur_ff});
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tgt_ff       <= '0;
         cur_ff       <= '0;
         rest_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tgt_ff       <= tgt_in;
         cur_ff       <= cur_in;
         rest_ff      <= rest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gv_ff       <= gv_in;
      gaze_ff     <= gaze_in;
      dt_ff       <= dt_in;
      top_ff      <= top_in;
      bh_ff       <= bh_in;
      zt_ff       <= zt_in;
      zb_ff       <= zb_in;
      reach_ff    <= reach_in;
      wt_ff       <= wt_in;
      n_ff        <= n_in;
      f_ff        <= f_in;
      t_ff        <= t_in;
      sum_ff      <= sum_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while result pending");
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy) else $error("divider restarted while busy");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> rsp_valid_ff) else $error("result state without valid");
endmodule
`default_nettype wire

// File: tb/tb_gaze_follow_crop_offset.sv
// Testbench for the gaze-follow crop offset block: directed table, random phases, predictor check.
`timescale 1ns / 100ps
`default_nettype none
module tb_gaze_follow_crop_offset;
   import gfco_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MODE_FOLLOW    = 0;
   localparam int MODE_RETURN    = 1;
   localparam longint EXP1_Q30   = longint'(EXP_M1_Q30);

   typedef struct {
      bit        gv;
      bit [19:0] gaze;
      bit [14:0] dt;
      bit [11:0] top;
      bit [12:0] bh;
      bit        typed;
      bit [20:0] t_ofs;
      bit [11:0] t_row;
   } frame_req_t;

   typedef struct {
      bit [20:0] ofs;
      bit [11:0] row;
   } crop_out_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   gaze_follow_crop_offset dut (.*);

   always #5 clock = ~clock;

   // register copies and frame state of the predictor
   longint unsigned cfg_mode, cfg_dz, cfg_reach, cfg_hold, cfg_glide, cfg_keep, cfg_img;
   longint          st_target, st_current;
   longint unsigned st_rest;

   frame_req_t frame_q[$];
   frame_req_t req_now;
   crop_out_t  crop_q[$];
   bit         req_fire = 1'b0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         hold_left = 0;
   int         errors = 0;
   int         quiet_cycles = 0;
   bit [19:0]  last_gaze = '0;

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic longint clampl(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint sat21(input longint v);
      return clampl(v, -(64'sd1 <<< 20), (64'sd1 <<< 20) - 1);
   endfunction

   // glide gain 1-exp(-dt/glide) in Q16
   function automatic longint glide_gain_q16(input longint dt, input longint gl);
      longint x, n, f, s, t, e;
      if (gl == 0) return 65536;
      x = (dt << 16) / (gl << FRAC_BITS);
      n = x >> 16;
      f = x & 64'hFFFF;
      if (n >= 32) return 65536;
      s = 64'sd1 << 30;
      t = s;
      for (int i = 1; i <= TAYLOR_N; i++) begin
         t = ((t * f) >> 16) / i;
         if (i % 2 == 1) s = (t > s) ? 0 : s - t;
         else s = s + t;
      end
      if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
      for (longint i = 0; i < n; i++) s = (s * EXP1_Q30 + (64'sd1 << 29)) >> 30;
      e = (s + (64'sd1 << 13)) >> 14;
      if (e > 65536) e = 65536;
      return 65536 - e;
   endfunction

   // one frame of the crop-offset behaviour
   function automatic crop_out_t crop_frame(input frame_req_t r);
      longint home, bh, img, zt, zb, amin, amax, pushed, reach, keep, hi_lim, lo_lim;
      longint diff, mag, t, row, limit;
      crop_out_t o;
      bh   = r.bh;
      img  = cfg_img;
      home = longint'(r.top) << FRAC_BITS;
      if (!(cfg_mode[MODE_FOLLOW] && bh > 0 && bh < img)) begin
         st_target = 0;
         st_current = 0;
         st_rest = 0;
      end else begin
         if (r.gv) begin
            zt = (((65536 - longint'(cfg_dz)) * bh << FRAC_BITS) + (1 << 16)) >> 17;
            zb = (((65536 + longint'(cfg_dz)) * bh << FRAC_BITS) + (1 << 16)) >> 17;
            amin = longint'(r.gaze) - home - zb;
            amax = longint'(r.gaze) - home - zt;
            pushed = clampl(st_target, amin, amax);
            if (pushed != st_target) begin
               st_target = pushed;
               st_rest = 0;
            end else begin
               st_rest = st_rest + r.dt;
               if (st_rest > 24'hFFFFFF) st_rest = 24'hFFFFFF;
               if (cfg_mode[MODE_RETURN] && st_rest >= (cfg_hold << FRAC_BITS))
                  st_target = clampl(0, amin, amax);
            end
         end
         reach = ((longint'(cfg_reach) * bh << FRAC_BITS) + (1 << 15)) >> 16;
         st_target = clampl(st_target, -reach, reach);
         keep = longint'(cfg_keep) << FRAC_BITS;
         hi_lim = keep - home;
         if (hi_lim > 0) hi_lim = 0;
         lo_lim = ((img - bh) << FRAC_BITS) - home - keep;
         if (lo_lim < 0) lo_lim = 0;
         st_target = sat21(clampl(st_target, hi_lim, lo_lim));
         diff = st_target - st_current;
         mag = (diff < 0) ? -diff : diff;
         mag = (mag * glide_gain_q16(r.dt, cfg_glide) + 32768) >> 16;
         st_current = sat21(st_current + ((diff < 0) ? -mag : mag));
      end
      t = home + st_current + (1 << (FRAC_BITS - 1));
      row = (t < 0) ? 0 : (t >> FRAC_BITS);
      limit = (img > bh) ? img - bh : 0;
      if (limit > 4095) limit = 4095;
      if (row > limit) row = limit;
      o.ofs = st_current[20:0];
      o.row = row[11:0];
      return o;
   endfunction

   // register write through the configuration port, mirrored into the predictor
   task automatic write_reg(input logic [2:0] idx, input longint unsigned val);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = CSR_AW'({idx, 2'b00});
      csr_pwdata = val[31:0];
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      case (idx)
         REG_FOLLOW_MODE: cfg_mode = val & 64'h3;
         REG_DEADZONE:    cfg_dz = val & 64'hFFFF;
         REG_REACH:       cfg_reach = val & 64'hFFFF;
         REG_HOLD:        cfg_hold = val & 64'hFFFF;
         REG_GLIDE:       cfg_glide = val & 64'hFFFF;
         REG_EDGE_KEEP:   cfg_keep = val & 64'hFFF;
         REG_IMG_HEIGHT:  cfg_img = val & 64'h1FFF;
         default: ;
      endcase
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic write_all(input longint unsigned mode, dz, rch, hold, gl, keep, img);
      write_reg(REG_FOLLOW_MODE, mode);
      write_reg(REG_DEADZONE, dz);
      write_reg(REG_REACH, rch);
      write_reg(REG_HOLD, hold);
      write_reg(REG_GLIDE, gl);
      write_reg(REG_EDGE_KEEP, keep);
      write_reg(REG_IMG_HEIGHT, img);
   endtask

   // wait until every request is taken and every result has arrived
   task automatic drain;
      while (frame_q.size() > 0 || req_tvalid || crop_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic frame_req_t make_req(input bit gv, input int gaze, input int dt,
                                           input int top, input int bh);
      frame_req_t r;
      r.gv = gv;
      r.gaze = gaze[19:0];
      r.dt = dt[14:0];
      r.top = top[11:0];
      r.bh = bh[12:0];
      r.typed = 1'b0;
      r.t_ofs = '0;
      r.t_row = '0;
      return r;
   endfunction

   function automatic frame_req_t typed_req(input int top, input int bh, input int row);
      frame_req_t r;
      r = make_req(1'b1, 20'hFFFFF, 15'h7FFF, top, bh);
      r.typed = 1'b1;
      r.t_row = row[11:0];
      return r;
   endfunction

   // random frame, mostly a box inside the image with the gaze near it
   function automatic frame_req_t rand_req;
      frame_req_t r;
      int img, bh, top, g;
      img = int'(cfg_img);
      if ($urandom_range(99) < 6 || img < 4) begin
         r = make_req($urandom_range(1), $urandom, $urandom, $urandom, $urandom);
         if ($urandom_range(1)) last_gaze = r.gaze;
         return r;
      end
      bh  = $urandom_range(1, img - 1);
      top = $urandom_range(0, (img - bh > 4095) ? 4095 : img - bh);
      if ($urandom_range(99) < 45) g = last_gaze;
      else g = (top << 8) + $urandom_range(0, bh << 8) + $urandom_range(0, bh << 8)
               - (bh << 7) - (bh << 6);
      if (g < 0) g = 0;
      if (g > 20'hFFFFF) g = 20'hFFFFF;
      last_gaze = g[19:0];
      r = make_req($urandom_range(99) < 88, g,
                   ($urandom_range(9) == 0) ? $urandom_range(0, 32767)
                                            : $urandom_range(2000, 9000), top, bh);
      return r;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (frame_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_now = frame_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= req_now.gv;
            req_tdata <= {4'b0, req_now.bh, req_now.top, req_now.dt, req_now.gaze};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      rsp_tready <= !reset && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
   end

   // long hold-off counter
   always @(negedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      crop_out_t e, p;
      req_fire = req_tvalid && req_tready;
      if (req_fire) begin
         p = crop_frame(req_now);
         if (req_now.typed) begin
            p.ofs = req_now.t_ofs;
            p.row = req_now.t_row;
         end
         crop_q.push_back(p);
      end
      if (rsp_tvalid && rsp_tready) begin
         if (crop_q.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            e = crop_q.pop_front();
            if (rsp_tdata[20:0] !== e.ofs)
               report_mismatch($sformatf("glided_offset %h, expected %h", rsp_tdata[20:0], e.ofs));
            if (rsp_tdata[32:21] !== e.row)
               report_mismatch($sformatf("crop_row %0d, expected %0d", rsp_tdata[32:21], e.row));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || req_fire || (rsp_tvalid && rsp_tready) || csr_psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL gaze_follow_crop_offset");
         $finish;
      end
   end

   initial begin
      cfg_mode = 0; cfg_dz = 32768; cfg_reach = 16384; cfg_hold = 2000;
      cfg_glide = 300; cfg_keep = 0; cfg_img = 1080;
      st_target = 0; st_current = 0; st_rest = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset follow is off: offset zero, row is the box top clamped
      frame_q.push_back(typed_req(100, 500, 100));
      frame_q.push_back(typed_req(4095, 1000, 80));
      frame_q.push_back(typed_req(50, 0, 50));
      frame_q.push_back(typed_req(7, 1080, 0));
      frame_q.push_back(typed_req(4095, 8191, 0));
      drain();
      // image height zero: follow off and row zero
      write_reg(REG_IMG_HEIGHT, 0);
      write_reg(REG_FOLLOW_MODE, 3);
      frame_q.push_back(typed_req(300, 20, 0));
      drain();

      // follow on, jump at once, hold zero, widest reach
      write_all(3, 0, 65535, 0, 0, 0, 4096);
      frame_q.push_back(make_req(1, 20'hFFFFF, 4266, 0, 1));
      frame_q.push_back(make_req(1, 0, 4266, 4095, 1));
      frame_q.push_back(make_req(0, 0, 32767, 2000, 1000));
      frame_q.push_back(make_req(1, 2500 << 8, 0, 2000, 1000));
      frame_q.push_back(make_req(1, 2500 << 8, 32767, 2000, 1000));
      frame_q.push_back(make_req(1, 0, 25600, 0, 4095));
      frame_q.push_back(make_req(1, 20'hFFFFF, 25600, 1, 4095));
      drain();
      // slowest glide, full deadzone, no reach, widest edge keep
      write_all(1, 65535, 0, 65535, 65535, 4095, 4096);
      frame_q.push_back(make_req(1, 20'hFFFFF, 32767, 100, 2000));
      frame_q.push_back(make_req(1, 0, 1, 100, 2000));
      drain();
      // small glide so the ratio passes 32, timer runs long
      write_all(3, 1000, 40000, 65535, 1, 10, 1080);
      frame_q.push_back(make_req(1, 900 << 8, 32767, 200, 400));
      frame_q.push_back(make_req(1, 100 << 8, 32767, 200, 400));
      frame_q.push_back(make_req(1, 100 << 8, 25600, 200, 400));
      frame_q.push_back(make_req(0, 100 << 8, 25600, 200, 400));
      drain();

      // random phases with changing settings and idling
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 0) write_all(3, 0, 65535, 0, 0, 0, 4096);
         else if (ph == 1) write_all(2, 65535, 0, 65535, 65535, 4095, 1);
         else if (ph == 2) write_all(3, 65535, 65535, 0, 0, 4095, 8191);
         else write_all(($urandom_range(4) == 0) ? $urandom_range(0, 3)
                                                 : ($urandom_range(0, 1) * 2 + 1),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 300), $urandom_range(0, 600),
                        $urandom_range(0, 63), $urandom_range(64, 4096));
         send_idle_pct  = (ph % 4 == 1) ? 72 : (ph % 4 == 3) ? 13 : 0;
         recv_stall_pct = (ph % 4 == 2) ? 72 : (ph % 4 == 3) ? 13 : 0;
         if (ph == 5) hold_left = 3000;
         for (int i = 0; i < 175; i++) frame_q.push_back(rand_req());
         drain();
      end

      repeat (600) @(posedge clock);
      if (errors == 0) $display("PASS gaze_follow_crop_offset");
      else $display("FAIL gaze_follow_crop_offset");
      $finish;
   end
endmodule
`default_nettype wire
